[rtl/core/fit_block_allocator_unit_defines.svh]
// ----------------------------------------------------------------------------
// fit_block_allocator_unit_defines
// assertion macros used by the allocator rtl
// ----------------------------------------------------------------------------
`ifndef FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define FBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/fba_pkg.sv]
// ----------------------------------------------------------------------------
// fba_pkg
// types and constants of the fit block allocator
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
    localparam int SIZE_W     = 16;
    localparam int MODE_W     = 2;
    localparam int ACT_W      = 5;
    localparam int CFG_W      = 5;

    localparam logic CFG_FIT_MODE      = 1'b0;
    localparam logic CFG_ACTIVE_BLOCKS = 1'b1;

    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    typedef enum logic [1:0] {
        STAT_LOADED = 2'd0,
        STAT_PLACED = 2'd1,
        STAT_NOFIT  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0] fit_mode;
        logic [CNT_W-1:0]  limit;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        t_status           status;
        logic [IDX_W-1:0]  chosen;
        logic [SIZE_W-1:0] remain;
        logic              last;
    } t_result;

endpackage

[rtl/core/fba_table_ram.sv]
// ----------------------------------------------------------------------------
// fba_table_ram
// free size table, one write and one registered read port
// ----------------------------------------------------------------------------
module fba_table_ram
    import fba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  logic [SIZE_W-1:0] i_wdata,
    input  logic [IDX_W-1:0]  i_raddr,
    output logic [SIZE_W-1:0] o_rdata
);

    logic [SIZE_W-1:0] r_mem [NUM_BLOCKS];
    logic [SIZE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/fba_scan_ctrl.sv]
// ----------------------------------------------------------------------------
// fba_scan_ctrl
// sequencer to write load beats, or scan the table, pick a fitting block, write it back
// ----------------------------------------------------------------------------
module fba_scan_ctrl
    import fba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_action,
    input  logic [IDX_W-1:0]  i_load_index,
    input  logic [SIZE_W-1:0] i_block_size,
    input  logic [SIZE_W-1:0] i_request_size,
    input  logic              i_last_request,
    input  t_cfg              i_cfg,
    input  logic [SIZE_W-1:0] i_ram_rdata,
    output logic              o_busy,
    output logic              o_ram_we,
    output logic [IDX_W-1:0]  o_ram_waddr,
    output logic [SIZE_W-1:0] o_ram_wdata,
    output logic [IDX_W-1:0]  o_ram_raddr,
    output t_result           o_res
);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_cnt;
    logic              r_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic [SIZE_W-1:0] r_need;
    logic              r_last;
    logic              r_found;
    logic [IDX_W-1:0]  r_pick_idx;
    logic [SIZE_W-1:0] r_pick_size;

    logic              accept;
    logic              take;
    logic [SIZE_W-1:0] left_size;
    logic [CNT_W-1:0]  last_addr;

    assign accept    = i_start && (r_state == ST_IDLE);
    assign last_addr = CNT_W'(i_cfg.limit - CNT_W'(1));
    assign left_size = r_pick_size - r_need;
    assign o_busy    = (r_state != ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_action) begin
                    n_state = (i_cfg.limit == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if ({1'b0, r_cnt} == last_addr) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        take        = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = i_load_index;
        o_ram_wdata = i_block_size;
        o_ram_raddr = r_cnt;
        o_res       = '0;
        o_res.status = STAT_LOADED;

        if (r_cmp_vld && (i_ram_rdata >= r_need)) begin
            if (!r_found) begin
                take = 1'b1;
            end else if (i_cfg.fit_mode == FIT_BEST) begin
                take = (i_ram_rdata < r_pick_size);
            end else if (i_cfg.fit_mode == FIT_WORST) begin
                take = (i_ram_rdata > r_pick_size);
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (accept && !i_action) begin
                    o_ram_we     = 1'b1;
                    o_res.valid  = 1'b1;
                    o_res.status = STAT_LOADED;
                    o_res.chosen = i_load_index;
                    o_res.remain = i_block_size;
                    o_res.last   = i_last_request;
                end
            end
            ST_DONE: begin
                o_res.valid = 1'b1;
                o_res.last  = r_last;
                if (r_found) begin
                    o_ram_we     = 1'b1;
                    o_ram_waddr  = r_pick_idx;
                    o_ram_wdata  = left_size;
                    o_res.status = STAT_PLACED;
                    o_res.chosen = r_pick_idx;
                    o_res.remain = left_size;
                end else begin
                    o_res.status = STAT_NOFIT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == ST_SCAN);
            if (accept) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else begin
                if (r_state == ST_SCAN) begin
                    r_cnt <= r_cnt + IDX_W'(1);
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_cnt;
        if (accept) begin
            r_need <= i_request_size;
            r_last <= i_last_request;
        end
        if (take) begin
            r_pick_idx  <= r_cmp_idx;
            r_pick_size <= i_ram_rdata;
        end
    end

endmodule

[rtl/core/fit_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// fit_block_allocator_unit
// free size table with first, best and worst fit allocation
// ----------------------------------------------------------------------------
//  channel   handshake             fields
//  item in   i_start, o_busy       i_action, i_load_index, i_block_size,
//                                  i_request_size, i_last_request
//  result    o_done                o_status, o_chosen_block, o_remaining_size,
//                                  o_last
//  config    i_cfg_we              i_cfg_addr, i_cfg_data
//
//  a load beat writes the table at accept and its result shows the next cycle
//  a request reads one entry a cycle through the table ram port, busy through
//  scan, drain and done (straight to done with no active block)
//  the request result shows in the first cycle with busy low
//  reset clears the state machine, config and result strobe; the table has none
//  results are never stalled, the next beat may be taken while one is shown
// ----------------------------------------------------------------------------
`include "fit_block_allocator_unit_defines.svh"

module fit_block_allocator_unit
    import fba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic              i_action,
    input  logic [IDX_W-1:0]  i_load_index,
    input  logic [SIZE_W-1:0] i_block_size,
    input  logic [SIZE_W-1:0] i_request_size,
    input  logic              i_last_request,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [IDX_W-1:0]  o_chosen_block,
    output logic [SIZE_W-1:0] o_remaining_size,
    output logic              o_last
);

    logic [MODE_W-1:0] r_fit_mode;
    logic [ACT_W-1:0]  r_active_blocks;
    t_cfg              cfg;
    t_result           res;
    t_result           r_res;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [SIZE_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [SIZE_W-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode      <= FIT_FIRST;
            r_active_blocks <= ACT_W'(NUM_BLOCKS);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FIT_MODE:      r_fit_mode      <= i_cfg_data[MODE_W-1:0];
                CFG_ACTIVE_BLOCKS: r_active_blocks <= i_cfg_data[ACT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // saturate to the table depth
    always_comb begin
        cfg.fit_mode = r_fit_mode;
        if (CNT_W'(r_active_blocks) > CNT_W'(NUM_BLOCKS)) begin
            cfg.limit = CNT_W'(NUM_BLOCKS);
        end else begin
            cfg.limit = CNT_W'(r_active_blocks);
        end
    end

    fba_table_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fba_scan_ctrl u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_action       (i_action),
        .i_load_index   (i_load_index),
        .i_block_size   (i_block_size),
        .i_request_size (i_request_size),
        .i_last_request (i_last_request),
        .i_cfg          (cfg),
        .i_ram_rdata    (ram_rdata),
        .o_busy         (o_busy),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_raddr    (ram_raddr),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else begin
            r_res.valid <= res.valid;
        end
        r_res.status <= res.status;
        r_res.chosen <= res.chosen;
        r_res.remain <= res.remain;
        r_res.last   <= res.last;
    end

    assign o_done           = r_res.valid;
    assign o_status         = r_res.status;
    assign o_chosen_block   = r_res.chosen;
    assign o_remaining_size = r_res.remain;
    assign o_last           = r_res.last;

    `FBA_ASSERT_NEXT(a_req_busy, i_start && !o_busy && i_action, o_busy && !o_done,
        "request beat did not start a scan")
    `FBA_ASSERT_NEXT(a_load_done, i_start && !o_busy && !i_action,
        o_done && o_status == STAT_LOADED, "load beat gave no loaded result")
    `FBA_ASSERT_NOW(a_nofit_zero, o_done && o_status == STAT_NOFIT,
        o_chosen_block == '0 && o_remaining_size == '0, "no fit result not cleared")
    `FBA_ASSERT_NOW(a_pick_range, o_done && o_status == STAT_PLACED,
        CNT_W'(o_chosen_block) < cfg.limit, "placed block beyond active range")

endmodule

[tb/sv/fit_block_allocator_unit_tb.sv]
// ----------------------------------------------------------------------------
// fit_block_allocator_unit_tb
// self-checking bench for the first, best and worst fit allocator
// ----------------------------------------------------------------------------
//  a queue of load and request beats feeds a clocked driver in random bursts
//  the monitor predicts each accepted beat from a local table and config copy
//  every result checked field by field
//  all fit modes and a range of active block counts, directed then random
// ----------------------------------------------------------------------------
module fit_block_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fba_pkg::*;

    localparam logic [MODE_W-1:0] FIT_UNUSED = 2'd3;
    localparam int PHASES     = 10;
    localparam int PHASE_CMDS = 145;

    typedef struct {
        logic              action;
        logic [IDX_W-1:0]  load_idx;
        logic [SIZE_W-1:0] blk_size;
        logic [SIZE_W-1:0] req_size;
        logic              last;
    } t_alloc_cmd;

    typedef struct {
        t_status           status;
        logic [IDX_W-1:0]  block;
        logic [SIZE_W-1:0] remain;
        logic              last;
    } t_alloc_resp;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic              o_busy;
    logic              i_action = 1'b0;
    logic [IDX_W-1:0]  i_load_index = '0;
    logic [SIZE_W-1:0] i_block_size = '0;
    logic [SIZE_W-1:0] i_request_size = '0;
    logic              i_last_request = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_addr = 1'b0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              o_done;
    logic [1:0]        o_status;
    logic [IDX_W-1:0]  o_chosen_block;
    logic [SIZE_W-1:0] o_remaining_size;
    logic              o_last;

    t_alloc_cmd  cmd_q[$];
    t_alloc_resp resp_exp_q[$];

    logic [SIZE_W-1:0] free_tbl [NUM_BLOCKS];
    logic [MODE_W-1:0] mode_cfg = FIT_FIRST;
    logic [ACT_W-1:0]  act_cfg = ACT_W'(NUM_BLOCKS);
    int                err_count = 0;
    int                burst_left = 0;
    int                gap_left = 0;

    fit_block_allocator_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_action         (i_action),
        .i_load_index     (i_load_index),
        .i_block_size     (i_block_size),
        .i_request_size   (i_request_size),
        .i_last_request   (i_last_request),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_chosen_block   (o_chosen_block),
        .o_remaining_size (o_remaining_size),
        .o_last           (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // load writes one entry, request searches the active entries by policy
    function automatic t_alloc_resp apply_cmd(t_alloc_cmd c);
        t_alloc_resp r;
        int lim;
        int pick;
        logic [SIZE_W-1:0] pick_sz;
        r.status = STAT_LOADED;
        r.block  = c.load_idx;
        r.remain = '0;
        r.last   = c.last;
        if (!c.action) begin
            free_tbl[c.load_idx] = c.blk_size;
            r.remain = c.blk_size;
        end else begin
            lim = (act_cfg > NUM_BLOCKS) ? NUM_BLOCKS : int'(act_cfg);
            pick = -1;
            pick_sz = '0;
            for (int j = 0; j < lim; j++) begin
                if (free_tbl[j] >= c.req_size) begin
                    if (pick < 0) begin
                        pick = j;
                        pick_sz = free_tbl[j];
                        if (mode_cfg != FIT_BEST && mode_cfg != FIT_WORST)
                            break;
                    end else if (mode_cfg == FIT_BEST && free_tbl[j] < pick_sz) begin
                        pick = j;
                        pick_sz = free_tbl[j];
                    end else if (mode_cfg == FIT_WORST && free_tbl[j] > pick_sz) begin
                        pick = j;
                        pick_sz = free_tbl[j];
                    end
                end
            end
            r.block = '0;
            if (pick < 0) begin
                r.status = STAT_NOFIT;
            end else begin
                free_tbl[pick] = pick_sz - c.req_size;
                r.status = STAT_PLACED;
                r.block  = IDX_W'(pick);
                r.remain = free_tbl[pick];
            end
        end
        return r;
    endfunction

    function automatic t_alloc_cmd rand_cmd(int span);
        t_alloc_cmd c;
        c.action = ($urandom_range(0, 99) >= 35);
        if (span == 0 || $urandom_range(0, 3) == 0)
            c.load_idx = IDX_W'($urandom);
        else
            c.load_idx = IDX_W'($urandom_range(0, span - 1));
        case ($urandom_range(0, 9))
            0:       c.blk_size = '0;
            1:       c.blk_size = '1;
            2, 3:    c.blk_size = SIZE_W'($urandom_range(0, 255));
            default: c.blk_size = SIZE_W'($urandom);
        endcase
        case ($urandom_range(0, 11))
            0:          c.req_size = '0;
            1:          c.req_size = '1;
            2:          c.req_size = SIZE_W'($urandom);
            3, 4, 5, 6: c.req_size = SIZE_W'($urandom_range(0, 511));
            7:          c.req_size = free_tbl[c.load_idx];
            default:    c.req_size = SIZE_W'($urandom_range(0, 4095));
        endcase
        c.last = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic t_alloc_cmd make_cmd(logic act, int idx, int bsz, int rsz, logic lst);
        t_alloc_cmd c;
        c.action   = act;
        c.load_idx = IDX_W'(idx);
        c.blk_size = SIZE_W'(bsz);
        c.req_size = SIZE_W'(rsz);
        c.last     = lst;
        return c;
    endfunction

    task automatic check_field(string what, logic [SIZE_W-1:0] want, logic [SIZE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            err_count++;
        end
    endtask

    task automatic write_cfg(logic [MODE_W-1:0] mode, logic [ACT_W-1:0] act);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_FIT_MODE;
        i_cfg_data <= CFG_W'(mode);
        @(posedge i_clk);
        i_cfg_addr <= CFG_ACTIVE_BLOCKS;
        i_cfg_data <= CFG_W'(act);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mode_cfg = mode;
        act_cfg  = act;
    endtask

    // wait for the sender to empty and all results to land
    task automatic settle();
        int waited;
        waited = 0;
        while (cmd_q.size() != 0 || i_start)
            @(negedge i_clk);
        while (resp_exp_q.size() != 0 && waited < 200) begin
            @(negedge i_clk);
            waited++;
        end
        if (resp_exp_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, resp_exp_q.size());
            err_count += resp_exp_q.size();
            resp_exp_q.delete();
        end
        repeat (30) @(negedge i_clk);
    endtask

    // driver: one beat at a time from the command queue, bursts and gaps
    always @(posedge i_clk) begin
        t_alloc_cmd c;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || !o_busy) begin
            if (gap_left != 0) begin
                gap_left--;
                i_start <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                c = cmd_q.pop_front();
                i_action       <= c.action;
                i_load_index   <= c.load_idx;
                i_block_size   <= c.blk_size;
                i_request_size <= c.req_size;
                i_last_request <= c.last;
                i_start        <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
                end else begin
                    burst_left--;
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: check the shown result first, then predict a newly taken beat
    always @(posedge i_clk) begin
        t_alloc_resp want;
        t_alloc_cmd  seen;
        if (i_rst_n) begin
            if (o_done) begin
                if (resp_exp_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual status %0d",
                             $time, o_status);
                    err_count++;
                end else begin
                    want = resp_exp_q.pop_front();
                    check_field("status", SIZE_W'(want.status), SIZE_W'(o_status));
                    check_field("chosen_block", SIZE_W'(want.block), SIZE_W'(o_chosen_block));
                    check_field("remaining_size", want.remain, o_remaining_size);
                    check_field("last", SIZE_W'(want.last), SIZE_W'(o_last));
                end
            end
            if (i_start && !o_busy) begin
                seen.action   = i_action;
                seen.load_idx = i_load_index;
                seen.blk_size = i_block_size;
                seen.req_size = i_request_size;
                seen.last     = i_last_request;
                resp_exp_q.push_back(apply_cmd(seen));
            end
        end
    end

    initial begin
        int init_sizes[NUM_BLOCKS] = '{0, 65535, 300, 50, 1200, 50, 7, 4096,
                                       21845, 43690, 999, 1, 2, 60000, 500, 250};
        logic [MODE_W-1:0] mode_list[PHASES] = '{FIT_FIRST, FIT_BEST, FIT_WORST,
                                                 FIT_UNUSED, FIT_BEST, FIT_WORST,
                                                 FIT_FIRST, FIT_BEST, FIT_WORST,
                                                 FIT_FIRST};
        int act_list[PHASES] = '{16, 16, 1, 0, 31, 16, 1, 8, 3, 17};
        int span;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // every entry is loaded before the first request
        for (int k = 0; k < NUM_BLOCKS; k++)
            cmd_q.push_back(make_cmd(1'b0, k, init_sizes[k], 16'hFFFF - k, k[0]));
        cmd_q.push_back(make_cmd(1'b1, 15, 65535, 0, 1'b0));
        cmd_q.push_back(make_cmd(1'b1, 0, 0, 65535, 1'b1));
        cmd_q.push_back(make_cmd(1'b1, 9, 12345, 65535, 1'b0));
        cmd_q.push_back(make_cmd(1'b1, 3, 0, 60000, 1'b0));
        cmd_q.push_back(make_cmd(1'b1, 6, 65535, 50, 1'b1));
        cmd_q.push_back(make_cmd(1'b1, 2, 1, 24576, 1'b0));
        cmd_q.push_back(make_cmd(1'b0, 15, 0, 7, 1'b1));
        settle();

        for (int p = 0; p < PHASES; p++) begin
            if (p != 0)
                write_cfg(mode_list[p], ACT_W'(act_list[p]));
            @(negedge i_clk);
            span = (act_list[p] > NUM_BLOCKS) ? NUM_BLOCKS : act_list[p];
            for (int k = 0; k < PHASE_CMDS; k++)
                cmd_q.push_back(rand_cmd(span));
            settle();
        end

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
